/* src/ljfs_pkg.sv */
package ljfs_pkg;

  typedef logic [15:0] id_field_t;
  typedef logic [15:0] burst_field_t;
  typedef logic [19:0] time_field_t;
  typedef logic [23:0] total_field_t;

  typedef struct packed {
    id_field_t    job_id;
    burst_field_t burst;
    logic         last_job;
  } job_t;

  typedef struct packed {
    id_field_t    out_id;
    burst_field_t out_burst;
    time_field_t  wait_res;
    time_field_t  turnaround;
    logic         is_last;
    total_field_t total_wait;
    total_field_t total_turnaround;
    time_field_t  avg_wait;
    time_field_t  avg_turnaround;
    logic         overflow;
  } result_t;

  // Command broadcast to every cell of the sorted chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

/* src/ljfs_stream_if.sv */
interface ljfs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/ljfs_cell.sv */
module ljfs_cell #(
  parameter int ID_BITS    = 16,
  parameter int BURST_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ljfs_pkg::cell_ctrl_t   ctrl,
  input  logic [ID_BITS-1:0]     new_id,
  input  logic [BURST_BITS-1:0]  new_burst,
  input  logic                   prev_valid,
  input  logic [ID_BITS-1:0]     prev_id,
  input  logic [BURST_BITS-1:0]  prev_burst,
  input  logic                   prev_before,
  input  logic                   next_valid,
  input  logic [ID_BITS-1:0]     next_id,
  input  logic [BURST_BITS-1:0]  next_burst,
  output logic                   valid,
  output logic [ID_BITS-1:0]     id,
  output logic [BURST_BITS-1:0]  burst,
  output logic                   ahead
);

  // The held job is scheduled ahead of the incoming one: longer burst, or
  // equal burst and smaller id.
  assign ahead = valid && ((burst > new_burst) || ((burst == new_burst) && (id < new_id)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.insert && !ahead) begin
      valid <= prev_before ? 1'b1 : prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      id    <= next_id;
      burst <= next_burst;
    end else if (ctrl.insert && !ahead) begin
      if (prev_before) begin
        id    <= new_id;
        burst <= new_burst;
      end else begin
        id    <= prev_id;
        burst <= prev_burst;
      end
    end
  end

endmodule

/* src/ljfs_div.sv */
module ljfs_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [STEP_W-1:0]     step;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One restoring step per cycle, quotient bits enter from the right.
  assign shifted  = {rem_r, quo[DIVIDEND_W-1]};
  assign fits     = shifted >= {1'b0, dsr};
  assign diff     = shifted - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(DIVIDEND_W);
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem_r <= '0;
      dsr   <= divisor;
    end else if (busy) begin
      quo   <= {quo[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

endmodule

/* src/longest_job_first_scheduler_core.sv */
// Longest-job-first batch scheduler.
// Jobs arrive on the jobs channel, one request per job, carrying an id, a
// burst length and a last_job flag. Each accepted job is inserted into a
// chain of sorted cells in the cycle it is accepted, so jobs can be taken one
// per cycle. Jobs beyond MAX_JOBS are dropped and the batch is flagged.
// The job with last_job set closes the batch: the block then stops taking
// jobs and streams one result per stored job on the results channel, longest
// burst first, equal bursts by smaller id. Each result carries wait and
// turnaround time; the last one also carries totals and averages.
// The first result passes through the S_EMIT state and the output register
// after the closing job. Results leave one per cycle from the head of the
// chain while the receiver keeps up. The final result waits for two
// bit-serial dividers that run side by side, one quotient bit per cycle.
// When the receiver stalls, the output register holds its result and the
// chain stops shifting until the result is taken; a new batch can be taken
// while the final result of the previous one still waits.
// Reset empties the chain, clears the job count and the drop flag.
module longest_job_first_scheduler_core #(
  parameter int MAX_JOBS   = 16,
  parameter int ID_BITS    = 16,
  parameter int BURST_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  ljfs_stream_if.sink   jobs,
  ljfs_stream_if.source results
);

  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int WAIT_W = BURST_BITS + $clog2(MAX_JOBS);
  localparam int SUM_W  = WAIT_W + $clog2(MAX_JOBS);

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_EMIT    = 2'd1;
  localparam logic [1:0] S_FIN     = 2'd2;
  localparam logic [1:0] S_DIV     = 2'd3;

  logic [1:0]            state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      batch_n;
  logic                  dropped;
  logic [WAIT_W-1:0]     run_wait;
  logic [WAIT_W-1:0]     ta;
  logic [SUM_W-1:0]      acc;
  logic [SUM_W-1:0]      tot_t_sum;
  logic [SUM_W-1:0]      tot_t;
  logic                  out_valid;
  ljfs_pkg::result_t     out_data;
  ljfs_pkg::id_field_t    fin_id;
  ljfs_pkg::burst_field_t fin_burst;
  ljfs_pkg::time_field_t  fin_wait;
  ljfs_pkg::time_field_t  fin_ta;

  logic                  take_in;
  logic                  full;
  logic                  slot_free;
  logic                  emit_step;
  logic                  fin_load;
  logic                  div_start;
  logic                  wdiv_busy;
  logic                  tdiv_busy;
  logic [SUM_W-1:0]      avg_w;
  logic [SUM_W-1:0]      avg_t;
  ljfs_pkg::cell_ctrl_t  ctrl;

  logic [ID_BITS-1:0]    new_id;
  logic [BURST_BITS-1:0] new_burst;
  logic [MAX_JOBS-1:0]   cell_valid;
  logic [MAX_JOBS-1:0]   cell_before;
  logic [ID_BITS-1:0]    cell_id    [MAX_JOBS];
  logic [BURST_BITS-1:0] cell_burst [MAX_JOBS];

  assign jobs.ready    = (state == S_COLLECT);
  assign take_in       = jobs.valid && jobs.ready;
  assign full          = (count == CNT_W'(MAX_JOBS));
  assign slot_free     = !out_valid || results.ready;
  assign emit_step     = (state == S_EMIT) && slot_free;
  assign div_start     = (state == S_FIN);
  assign fin_load      = (state == S_DIV) && !wdiv_busy && !tdiv_busy && slot_free;
  assign ctrl.insert   = take_in && !full;
  assign ctrl.shift    = emit_step;
  assign new_id        = ID_BITS'(jobs.payload.job_id);
  assign new_burst     = BURST_BITS'(jobs.payload.burst);
  assign ta            = run_wait + WAIT_W'(cell_burst[0]);
  // Total turnaround is the total wait plus the finishing time of the batch.
  assign tot_t_sum     = acc + SUM_W'(run_wait);

  assign results.valid   = out_valid;
  assign results.payload = out_data;

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    logic                  p_valid;
    logic [ID_BITS-1:0]    p_id;
    logic [BURST_BITS-1:0] p_burst;
    logic                  p_before;
    logic                  n_valid;
    logic [ID_BITS-1:0]    n_id;
    logic [BURST_BITS-1:0] n_burst;

    if (i == 0) begin : g_head
      assign p_valid  = 1'b0;
      assign p_id     = '0;
      assign p_burst  = '0;
      assign p_before = 1'b1;
    end else begin : g_body
      assign p_valid  = cell_valid[i-1];
      assign p_id     = cell_id[i-1];
      assign p_burst  = cell_burst[i-1];
      assign p_before = cell_before[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_id    = '0;
      assign n_burst = '0;
    end else begin : g_link
      assign n_valid = cell_valid[i+1];
      assign n_id    = cell_id[i+1];
      assign n_burst = cell_burst[i+1];
    end

    ljfs_cell #(
      .ID_BITS    (ID_BITS),
      .BURST_BITS (BURST_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_id      (new_id),
      .new_burst   (new_burst),
      .prev_valid  (p_valid),
      .prev_id     (p_id),
      .prev_burst  (p_burst),
      .prev_before (p_before),
      .next_valid  (n_valid),
      .next_id     (n_id),
      .next_burst  (n_burst),
      .valid       (cell_valid[i]),
      .id          (cell_id[i]),
      .burst       (cell_burst[i]),
      .ahead       (cell_before[i])
    );
  end

  ljfs_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_wait (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (batch_n),
    .busy     (wdiv_busy),
    .quotient (avg_w)
  );

  ljfs_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_turn (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tot_t_sum),
    .divisor  (batch_n),
    .busy     (tdiv_busy),
    .quotient (avg_t)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
      run_wait  <= '0;
      acc       <= '0;
    end else begin
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_COLLECT: begin
          if (take_in) begin
            if (!full) begin
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (jobs.payload.last_job) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            acc      <= acc + SUM_W'(run_wait);
            run_wait <= ta;
            count    <= count - 1'b1;
            // The final job is held back until its averages are ready.
            if (count == CNT_W'(1)) begin
              state <= S_FIN;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_FIN: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (fin_load) begin
            out_valid <= 1'b1;
            state     <= S_COLLECT;
            dropped   <= 1'b0;
            run_wait  <= '0;
            acc       <= '0;
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_in && jobs.payload.last_job) begin
      batch_n <= full ? count : count + 1'b1;
    end
    if (div_start) begin
      tot_t <= tot_t_sum;
    end
    if (emit_step && (count == CNT_W'(1))) begin
      fin_id    <= ljfs_pkg::id_field_t'(cell_id[0]);
      fin_burst <= ljfs_pkg::burst_field_t'(cell_burst[0]);
      fin_wait  <= ljfs_pkg::time_field_t'(run_wait);
      fin_ta    <= ljfs_pkg::time_field_t'(ta);
    end
    if (emit_step && (count != CNT_W'(1))) begin
      out_data.out_id           <= ljfs_pkg::id_field_t'(cell_id[0]);
      out_data.out_burst        <= ljfs_pkg::burst_field_t'(cell_burst[0]);
      out_data.wait_res         <= ljfs_pkg::time_field_t'(run_wait);
      out_data.turnaround       <= ljfs_pkg::time_field_t'(ta);
      out_data.is_last          <= 1'b0;
      out_data.total_wait       <= '0;
      out_data.total_turnaround <= '0;
      out_data.avg_wait         <= '0;
      out_data.avg_turnaround   <= '0;
      out_data.overflow         <= dropped;
    end else if (fin_load) begin
      out_data.out_id           <= fin_id;
      out_data.out_burst        <= fin_burst;
      out_data.wait_res         <= fin_wait;
      out_data.turnaround       <= fin_ta;
      out_data.is_last          <= 1'b1;
      out_data.total_wait       <= ljfs_pkg::total_field_t'(acc);
      out_data.total_turnaround <= ljfs_pkg::total_field_t'(tot_t);
      out_data.avg_wait         <= ljfs_pkg::time_field_t'(avg_w);
      out_data.avg_turnaround   <= ljfs_pkg::time_field_t'(avg_t);
      out_data.overflow         <= dropped;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_JOBS))
    else $error("job count exceeds capacity");

  a_chain_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_COLLECT) |-> ($countones(cell_valid) == int'(count)))
    else $error("occupied cells disagree with job count");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> cell_valid[0])
    else $error("head cell empty while results remain");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (wdiv_busy && tdiv_busy))
    else $error("dividers did not start");

endmodule
